/* hdl/cops_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cops_pkg;

   localparam int TICK_W  = 24;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = TICK_W;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_SHAPING_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_TICKS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MID_TICKS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_TICKS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REMOTE_TICKS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OTHER_TICKS  = 3'd5;

   // shaping modes
   localparam logic [MODE_W-1:0] MODE_FOLLOW = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TRIP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOTE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_OTHER  = 2'd3;

   // reset values, 1 ms ticks
   localparam logic [TICK_W-1:0] SHORT_RST  = 24'd2;
   localparam logic [TICK_W-1:0] MID_RST    = 24'd40;
   localparam logic [TICK_W-1:0] LONG_RST   = 24'd100;
   localparam logic [TICK_W-1:0] REMOTE_RST = 24'd250;
   localparam logic [TICK_W-1:0] OTHER_RST  = 24'd1000;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_START = 3'd1,
      PH_MID   = 3'd2,
      PH_LONG  = 3'd3,
      PH_HOLD  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TICK_W-1:0] short_ticks;
      logic [TICK_W-1:0] mid_ticks;
      logic [TICK_W-1:0] long_ticks;
      logic [TICK_W-1:0] remote_ticks;
      logic [TICK_W-1:0] other_ticks;
   } cfg_type;

endpackage

`default_nettype wire

/* hdl/command_output_pulse_shaper.sv */
`timescale 1ns / 1ps
`default_nettype none

// Command output pulse shaper.
// req channel: one transaction per timebase tick, carrying req_command_level.
// rsp channel: one transaction per req transaction, rsp_drive_out is the
// shaped drive level for that tick, in order.
// csr port: write-only registers (mode, short/mid/long/remote/other ticks);
// write only while no transaction is in flight.
// Each result is registered in the output register, or in the skid entry while rsp stalls.
// Throughput: one transaction per cycle while req_stall is low; the phase/count update
// is a single increment and compare stage between the state registers.
// An output register plus a one-entry skid register sit on rsp, so req keeps
// flowing while one result waits; req_stall rises only once both are full.
// Reset (synchronous) clears phase, tick count, both output entries and loads
// the register defaults (follow mode, thresholds for 1 ms ticks).
module command_output_pulse_shaper #(
   parameter int COUNT_WIDTH = 24
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_command_level,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_drive_out,
   input  wire                              csr_write,
   input  wire [cops_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [cops_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   cops_pkg::cfg_type   cfg_ff;
   cops_pkg::phase_type phase_ff;
   cops_pkg::phase_type phase_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic drive_in;

   logic out_valid_ff;
   logic out_data_ff;
   logic skid_valid_ff;
   logic skid_data_ff;

   logic req_take;
   logic rsp_take;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_drive_out = out_data_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= cops_pkg::MODE_FOLLOW;
         cfg_ff.short_ticks  <= cops_pkg::SHORT_RST;
         cfg_ff.mid_ticks    <= cops_pkg::MID_RST;
         cfg_ff.long_ticks   <= cops_pkg::LONG_RST;
         cfg_ff.remote_ticks <= cops_pkg::REMOTE_RST;
         cfg_ff.other_ticks  <= cops_pkg::OTHER_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            cops_pkg::REG_SHAPING_MODE: cfg_ff.mode <= csr_wdata[cops_pkg::MODE_W-1:0];
            cops_pkg::REG_SHORT_TICKS:  cfg_ff.short_ticks  <= csr_wdata;
            cops_pkg::REG_MID_TICKS:    cfg_ff.mid_ticks    <= csr_wdata;
            cops_pkg::REG_LONG_TICKS:   cfg_ff.long_ticks   <= csr_wdata;
            cops_pkg::REG_REMOTE_TICKS: cfg_ff.remote_ticks <= csr_wdata;
            cops_pkg::REG_OTHER_TICKS:  cfg_ff.other_ticks  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   cops_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .cfg       (cfg_ff),
      .cmd       (req_command_level),
      .phase     (phase_ff),
      .count     (count_ff),
      .phase_nxt (phase_in),
      .count_nxt (count_in),
      .drive     (drive_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cops_pkg::PH_IDLE;
         count_ff <= '0;
      end else if (req_take) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_data_ff  <= drive_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= drive_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

/* hdl/cops_step.sv */
`timescale 1ns / 1ps
`default_nettype none

// Next phase, next count and drive level for one tick.
module cops_step #(
   parameter int COUNT_WIDTH = 24
) (
   input  wire cops_pkg::cfg_type     cfg,
   input  wire                        cmd,
   input  wire cops_pkg::phase_type   phase,
   input  wire [COUNT_WIDTH-1:0]      count,
   output cops_pkg::phase_type        phase_nxt,
   output logic [COUNT_WIDTH-1:0]     count_nxt,
   output logic                       drive
);

   localparam int CMP_W = (COUNT_WIDTH > cops_pkg::TICK_W) ? COUNT_WIDTH : cops_pkg::TICK_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0]      inc;
   logic [COUNT_WIDTH-1:0]      limit_clamped;
   logic [cops_pkg::TICK_W-1:0] limit;

   function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
                                    input logic [cops_pkg::TICK_W-1:0] t);
      reached = CMP_W'(c) >= CMP_W'(t);
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] clamp(input logic [cops_pkg::TICK_W-1:0] t);
      logic [CMP_W-1:0] t_ext;
      t_ext = CMP_W'(t);
      if (t_ext > CMP_W'(CNT_MAX)) clamp = CNT_MAX;
      else clamp = COUNT_WIDTH'(t_ext);
   endfunction

   assign inc = (count == CNT_MAX) ? count : count + 1'b1;

   always_comb begin
      unique case (cfg.mode)
         cops_pkg::MODE_TRIP:   limit = cfg.long_ticks;
         cops_pkg::MODE_REMOTE: limit = cfg.remote_ticks;
         default:               limit = cfg.other_ticks;
      endcase
   end

   assign limit_clamped = clamp(limit);

   always_comb begin
      phase_nxt = phase;
      count_nxt = count;
      unique case (cfg.mode)
         cops_pkg::MODE_FOLLOW: begin
         end
         cops_pkg::MODE_TRIP: begin
            if (cmd) begin
               unique case (phase)
                  cops_pkg::PH_IDLE: begin
                     phase_nxt = cops_pkg::PH_START;
                     count_nxt = inc;
                  end
                  cops_pkg::PH_START: begin
                     count_nxt = inc;
                     if (reached(inc, cfg.short_ticks)) phase_nxt = cops_pkg::PH_MID;
                  end
                  cops_pkg::PH_MID: begin
                     count_nxt = inc;
                     if (reached(inc, cfg.mid_ticks)) phase_nxt = cops_pkg::PH_LONG;
                  end
                  cops_pkg::PH_LONG: begin
                     count_nxt = inc;
                     if (reached(inc, cfg.long_ticks)) phase_nxt = cops_pkg::PH_HOLD;
                  end
                  cops_pkg::PH_HOLD: begin
                     count_nxt = limit_clamped;
                  end
                  default: begin
                     phase_nxt = cops_pkg::PH_IDLE;
                     count_nxt = '0;
                  end
               endcase
            end else if (phase == cops_pkg::PH_MID) begin
               // released in mid phase: stretch out to mid_ticks
               count_nxt = inc;
               if (reached(inc, cfg.mid_ticks)) begin
                  phase_nxt = cops_pkg::PH_IDLE;
                  count_nxt = '0;
               end
            end else begin
               phase_nxt = cops_pkg::PH_IDLE;
               count_nxt = '0;
            end
         end
         default: begin
            if (!cmd) begin
               phase_nxt = cops_pkg::PH_IDLE;
               count_nxt = '0;
            end else begin
               unique case (phase)
                  cops_pkg::PH_IDLE: begin
                     phase_nxt = cops_pkg::PH_START;
                     count_nxt = inc;
                  end
                  cops_pkg::PH_START: begin
                     count_nxt = inc;
                     if (reached(inc, limit)) phase_nxt = cops_pkg::PH_MID;
                  end
                  cops_pkg::PH_MID: begin
                     count_nxt = limit_clamped;
                  end
                  default: begin
                     // trip-only phases mean nothing here
                     phase_nxt = cops_pkg::PH_IDLE;
                     count_nxt = '0;
                  end
               endcase
            end
         end
      endcase
   end

   always_comb begin
      if (cfg.mode == cops_pkg::MODE_FOLLOW) drive = cmd;
      else drive = (count_nxt != '0) && !reached(count_nxt, limit);
   end

endmodule

`default_nettype wire

/* hdl/cops_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module cops_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_stall,
   input wire rsp_valid,
   input wire rsp_stall,
   input wire rsp_drive_out
);

   // nothing comes out of a reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // req is held off only while a result is waiting
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("req_stall with empty output");

   // rsp_valid is always high in the cycle after a transaction is accepted
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted transaction missing on rsp");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_drive_out)))
      else $error("stalled rsp transaction changed");

endmodule

bind command_output_pulse_shaper cops_checker u_cops_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_drive_out (rsp_drive_out)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SEGMENTS = 12;
   localparam int SEGMENT_TICKS = 15;
   localparam logic [cops_pkg::TICK_W-1:0] TICKS_MAX = '1;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [cops_pkg::CSR_IDX_W-1:0] index;
      logic [cops_pkg::TICK_W-1:0] data;
      bit cmd;
      bit known;
      bit drive;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command_level = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic rsp_drive_out;
   logic csr_write = 1'b0;
   logic [cops_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cops_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // shaper state as the block should hold it
   cops_pkg::cfg_type shape_cfg;
   cops_pkg::phase_type shape_phase;
   logic [cops_pkg::TICK_W-1:0] shape_count;

   logic drive_expected[$];
   stim_row_type directed_rows[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_off_req = 1'b0;
   bit hold_seen = 1'b0;

   always #4 clock = ~clock;

   command_output_pulse_shaper #(
      .COUNT_WIDTH(cops_pkg::TICK_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command_level(req_command_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_drive_out(rsp_drive_out),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   function automatic stim_row_type tick_row(bit cmd);
      return '{ROW_TICK, '0, '0, cmd, 1'b0, 1'b0};
   endfunction

   function automatic stim_row_type known_row(bit cmd, bit drive);
      return '{ROW_TICK, '0, '0, cmd, 1'b1, drive};
   endfunction

   function automatic stim_row_type write_row(logic [cops_pkg::CSR_IDX_W-1:0] index,
                                              logic [cops_pkg::TICK_W-1:0] data);
      return '{ROW_WRITE, index, data, 1'b0, 1'b0, 1'b0};
   endfunction

   function automatic logic [cops_pkg::TICK_W-1:0] rand_ticks();
      case ($urandom_range(15))
         0: return '0;
         1: return TICKS_MAX;
         2: return cops_pkg::TICK_W'($urandom_range(60, 13));
         3: return cops_pkg::TICK_W'($urandom);
         default: return cops_pkg::TICK_W'($urandom_range(12, 1));
      endcase
   endfunction

   function void shape_clear();
      shape_phase = cops_pkg::PH_IDLE;
      shape_count = '0;
   endfunction

   function void count_bump();
      if (shape_count != TICKS_MAX) shape_count = shape_count + 1'b1;
   endfunction

   function void apply_reg(logic [cops_pkg::CSR_IDX_W-1:0] index,
                           logic [cops_pkg::TICK_W-1:0] data);
      case (index)
         cops_pkg::REG_SHAPING_MODE: shape_cfg.mode = data[cops_pkg::MODE_W-1:0];
         cops_pkg::REG_SHORT_TICKS:  shape_cfg.short_ticks = data;
         cops_pkg::REG_MID_TICKS:    shape_cfg.mid_ticks = data;
         cops_pkg::REG_LONG_TICKS:   shape_cfg.long_ticks = data;
         cops_pkg::REG_REMOTE_TICKS: shape_cfg.remote_ticks = data;
         cops_pkg::REG_OTHER_TICKS:  shape_cfg.other_ticks = data;
         default: ;
      endcase
   endfunction

   // one tick of the shaper: updates phase/count, returns the drive level
   function bit shape_tick(bit cmd);
      logic [cops_pkg::TICK_W-1:0] limit;
      if (shape_cfg.mode == cops_pkg::MODE_FOLLOW) return cmd;
      if (shape_cfg.mode == cops_pkg::MODE_TRIP) begin
         limit = shape_cfg.long_ticks;
         if (cmd) begin
            case (shape_phase)
               cops_pkg::PH_IDLE: begin
                  shape_phase = cops_pkg::PH_START;
                  count_bump();
               end
               cops_pkg::PH_START: begin
                  count_bump();
                  if (shape_count >= shape_cfg.short_ticks) shape_phase = cops_pkg::PH_MID;
               end
               cops_pkg::PH_MID: begin
                  count_bump();
                  if (shape_count >= shape_cfg.mid_ticks) shape_phase = cops_pkg::PH_LONG;
               end
               cops_pkg::PH_LONG: begin
                  count_bump();
                  if (shape_count >= shape_cfg.long_ticks) shape_phase = cops_pkg::PH_HOLD;
               end
               cops_pkg::PH_HOLD: shape_count = shape_cfg.long_ticks;
               default: shape_clear();
            endcase
         end else if (shape_phase == cops_pkg::PH_MID) begin
            // released in mid phase: stretch up to mid_ticks
            count_bump();
            if (shape_count >= shape_cfg.mid_ticks) shape_clear();
         end else begin
            shape_clear();
         end
      end else begin
         limit = (shape_cfg.mode == cops_pkg::MODE_REMOTE) ? shape_cfg.remote_ticks
                                                           : shape_cfg.other_ticks;
         if (!cmd) begin
            shape_clear();
         end else begin
            case (shape_phase)
               cops_pkg::PH_IDLE: begin
                  shape_phase = cops_pkg::PH_START;
                  count_bump();
               end
               cops_pkg::PH_START: begin
                  count_bump();
                  if (shape_count >= limit) shape_phase = cops_pkg::PH_MID;
               end
               cops_pkg::PH_MID: shape_count = limit;
               default: shape_clear();
            endcase
         end
      end
      return (shape_count != '0) && (shape_count < limit);
   endfunction

   task automatic send_tick(bit cmd, bit known, bit drive);
      bit predicted;
      csr_write <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command_level <= cmd;
      do @(posedge clock); while (req_stall);
      predicted = shape_tick(cmd);
      drive_expected.push_back(known ? drive : predicted);
   endtask

   // wait until every transaction in flight has come out
   task automatic drain();
      req_valid <= 1'b0;
      csr_write <= 1'b0;
      while (drive_expected.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(logic [cops_pkg::CSR_IDX_W-1:0] index,
                            logic [cops_pkg::TICK_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg(index, data);
   endtask

   // mostly command pulses of random length, some short runs of random levels as noise
   task automatic send_pulses(int count);
      int sent;
      int hi;
      int lo;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 8) begin
            hi = $urandom_range(16, 1);
            lo = $urandom_range(8, 1);
            repeat (hi) send_tick(1'b1, 1'b0, 1'b0);
            repeat (lo) send_tick(1'b0, 1'b0, 1'b0);
            sent += hi + lo;
         end else begin
            hi = $urandom_range(6, 1);
            repeat (hi) send_tick(1'($urandom_range(1)), 1'b0, 1'b0);
            sent += hi;
         end
      end
   endtask

   always @(posedge clock) begin : rsp_side
      logic want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp transaction, drive_out=%0b", rsp_drive_out);
         end else begin
            want = drive_expected.pop_front();
            if (want !== rsp_drive_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("drive_out mismatch: expected %0b, actual %0b",
                           want, rsp_drive_out);
            end
         end
      end
      if (hold_off_req != hold_seen) begin
         hold_seen <= hold_off_req;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      shape_cfg = '{mode: cops_pkg::MODE_FOLLOW, short_ticks: cops_pkg::SHORT_RST,
                    mid_ticks: cops_pkg::MID_RST, long_ticks: cops_pkg::LONG_RST,
                    remote_ticks: cops_pkg::REMOTE_RST,
                    other_ticks: cops_pkg::OTHER_RST};
      shape_clear();

      // follow mode after reset
      directed_rows.push_back(known_row(1'b0, 1'b0));
      directed_rows.push_back(known_row(1'b1, 1'b1));
      // trip/close: stretched release, then run into hold
      directed_rows.push_back(write_row(cops_pkg::REG_SHAPING_MODE,
                                        cops_pkg::TICK_W'(cops_pkg::MODE_TRIP)));
      directed_rows.push_back(write_row(cops_pkg::REG_SHORT_TICKS, 24'd1));
      directed_rows.push_back(write_row(cops_pkg::REG_MID_TICKS, 24'd4));
      directed_rows.push_back(write_row(cops_pkg::REG_LONG_TICKS, 24'd5));
      directed_rows.push_back(tick_row(1'b1));
      directed_rows.push_back(tick_row(1'b1));
      directed_rows.push_back(tick_row(1'b0));
      directed_rows.push_back(tick_row(1'b0));
      repeat (6) directed_rows.push_back(tick_row(1'b1));
      // hold reloads the count with the largest limit
      directed_rows.push_back(write_row(cops_pkg::REG_LONG_TICKS, TICKS_MAX));
      directed_rows.push_back(known_row(1'b1, 1'b0));
      // hold phase means nothing in remote mode: cleared
      directed_rows.push_back(write_row(cops_pkg::REG_SHAPING_MODE,
                                        cops_pkg::TICK_W'(cops_pkg::MODE_REMOTE)));
      directed_rows.push_back(write_row(cops_pkg::REG_REMOTE_TICKS, 24'd1));
      directed_rows.push_back(known_row(1'b1, 1'b0));
      directed_rows.push_back(tick_row(1'b1));
      directed_rows.push_back(tick_row(1'b1));
      directed_rows.push_back(write_row(cops_pkg::REG_REMOTE_TICKS, TICKS_MAX));
      directed_rows.push_back(tick_row(1'b1));
      // full count carried into trip mode: increments saturate
      directed_rows.push_back(write_row(cops_pkg::REG_SHAPING_MODE,
                                        cops_pkg::TICK_W'(cops_pkg::MODE_TRIP)));
      directed_rows.push_back(tick_row(1'b1));
      directed_rows.push_back(tick_row(1'b1));
      directed_rows.push_back(tick_row(1'b0));
      // zero limit keeps the drive low
      directed_rows.push_back(write_row(cops_pkg::REG_SHAPING_MODE,
                                        cops_pkg::TICK_W'(cops_pkg::MODE_OTHER)));
      directed_rows.push_back(write_row(cops_pkg::REG_OTHER_TICKS, 24'd0));
      directed_rows.push_back(known_row(1'b1, 1'b0));
      directed_rows.push_back(known_row(1'b1, 1'b0));
      directed_rows.push_back(tick_row(1'b0));
      directed_rows.push_back(write_row(cops_pkg::REG_SHAPING_MODE,
                                        cops_pkg::TICK_W'(cops_pkg::MODE_FOLLOW)));
      directed_rows.push_back(known_row(1'b1, 1'b1));
      directed_rows.push_back(known_row(1'b0, 1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            if (r == 0 || directed_rows[r-1].kind == ROW_TICK) drain();
            write_reg(directed_rows[r].index, directed_rows[r].data);
         end else begin
            send_tick(directed_rows[r].cmd, directed_rows[r].known, directed_rows[r].drive);
         end
      end

      for (int setting = 0; setting < 3; setting++) begin
         drain();
         send_idle_pct = (setting == 0) ? 35 : (setting == 1) ? 81 : 0;
         rsp_idle_pct  = (setting == 0) ? 81 : (setting == 1) ? 35 : 0;
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            // state is kept across mode changes on purpose
            write_reg(cops_pkg::REG_SHAPING_MODE, cops_pkg::TICK_W'($urandom_range(3)));
            if ($urandom_range(9) < 6) write_reg(cops_pkg::REG_SHORT_TICKS, rand_ticks());
            if ($urandom_range(9) < 6) write_reg(cops_pkg::REG_MID_TICKS, rand_ticks());
            if ($urandom_range(9) < 6) write_reg(cops_pkg::REG_LONG_TICKS, rand_ticks());
            if ($urandom_range(9) < 6) write_reg(cops_pkg::REG_REMOTE_TICKS, rand_ticks());
            if ($urandom_range(9) < 6) write_reg(cops_pkg::REG_OTHER_TICKS, rand_ticks());
            // long receiver hold-off while req keeps coming, fills the block
            if (setting == 2 && seg == 4) hold_off_req <= ~hold_off_req;
            send_pulses(SEGMENT_TICKS);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/cops_pkg.sv
hdl/cops_step.sv
hdl/command_output_pulse_shaper.sv
hdl/cops_checker.sv
tb/testbench.sv
